/* rtl/core/mkt_pkg.sv */
// mkt_pkg: shared types, constants and the entry compare function of the MRU key table.
// Depends on nothing; used by every file in rtl/core.
`default_nettype none

package mkt_pkg;

    // Table depth and derived widths
    localparam int MAX_ENTRIES = 8;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CNT_OUT_W   = 5;

    // Request codes; code 3 is unused and changes nothing
    typedef enum logic [1:0] {
        REQ_ADD  = 2'd0,
        REQ_MARK = 2'd1,
        REQ_READ = 2'd2
    } t_req_type;

    // Incoming item
    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [47:0] peer_addr;
        logic [3:0]  slot_index;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [63:0]          out_key_high;
        logic [63:0]          out_key_low;
        logic [47:0]          out_peer_addr;
        logic                 earlier_duplicate;
        logic [CNT_OUT_W-1:0] entry_count;
        logic [CNT_OUT_W-1:0] unique_count;
        logic                 op_status;
    } t_out_item;

    // One table entry
    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [47:0] peer;
    } t_entry;

    // Write port of the entry store
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_store_wr;

    // Key compare, with optional peer address compare
    function automatic logic entry_match(input t_entry a, input t_entry b,
                                         input logic use_peer);
        logic key_eq;
        key_eq = (a.key_high == b.key_high) && (a.key_low == b.key_low);
        return key_eq && (!use_peer || (a.peer == b.peer));
    endfunction

endpackage

`default_nettype wire

/* rtl/core/mkt_store.sv */
// mkt_store: entry store of the MRU key table, one write and one registered read port.
// Depends on mkt_pkg.
`default_nettype none

module mkt_store
    import mkt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_store_wr        i_wr,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    output t_entry                o_rd_data
);

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd_data;

    // Write one entry, read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/core/mru_key_table.sv */
// mru_key_table: top level of the most-recently-used key table with its sequencer.
// Depends on mkt_pkg and mkt_store.
`default_nettype none

// The table keeps up to MAX_ENTRIES 128-bit keys with a 48-bit peer address each,
// position 0 being the most recent. Add moves an equal entry to the front or inserts
// a new one there (dropping the last when full); mark-active moves the entry at
// slot_index to the front; read returns the entry at slot_index and whether its key
// occurs earlier. Every result carries the entry count and the distinct key count.
// One item is handled at a time, and an item occupies the block until its result is
// handed on, since every compare goes through the single read port of the entry
// store and one shared comparator: a match scan, a shift of one entry at a time
// through a read and a write state, then a pairwise scan for the distinct key count.
// A finished result waits in an output register while the next item is accepted. The
// store needs no clearing after reset.

module mru_key_table
    import mkt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_item,
    input  wire logic     i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire logic     i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_CMP,
        S_MA_RD,
        S_MA_LD,
        S_SH_RD,
        S_SH_WR,
        S_UQ_RDI,
        S_UQ_LDI,
        S_UQ_RDJ,
        S_UQ_CMP,
        S_DONE
    } t_state;

    t_state           r_state,     n_state;
    t_entry           r_hold,      n_hold;
    logic [CNT_W-1:0] r_i,         n_i;
    logic [CNT_W-1:0] r_j,         n_j;
    logic [IDX_W-1:0] r_pos,       n_pos;
    logic [CNT_W-1:0] r_count,     n_count;
    logic [CNT_W-1:0] r_uniq,      n_uniq;
    logic             r_dup,       n_dup;
    logic             r_cap_en,    n_cap_en;
    logic [IDX_W-1:0] r_cap_idx,   n_cap_idx;
    t_entry           r_cap,       n_cap;
    logic             r_cap_dup,   n_cap_dup;
    logic             r_status,    n_status;
    logic             r_mode,      n_mode;
    t_out_item        r_out,       n_out;
    logic             r_out_valid, n_out_valid;

    t_store_wr        w_wr;
    logic [IDX_W-1:0] w_rd_addr;
    t_entry           w_rd_data;
    logic             w_use_peer;
    logic             w_hit;
    logic             w_slot_oor;
    logic             w_cap_here;

    mkt_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Shared comparator: read entry against the held entry
    assign w_use_peer = r_mode && (r_state == S_ADD_CMP);
    assign w_hit      = entry_match(w_rd_data, r_hold, w_use_peer);
    assign w_slot_oor = (CNT_OUT_W'(i_in_item.slot_index) >= CNT_OUT_W'(r_count));
    assign w_cap_here = r_cap_en && (r_i[IDX_W-1:0] == r_cap_idx);

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_hold      = r_hold;
        n_i         = r_i;
        n_j         = r_j;
        n_pos       = r_pos;
        n_count     = r_count;
        n_uniq      = r_uniq;
        n_dup       = r_dup;
        n_cap_en    = r_cap_en;
        n_cap_idx   = r_cap_idx;
        n_cap       = r_cap;
        n_cap_dup   = r_cap_dup;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_mode      = r_mode;
        w_wr        = '0;
        w_rd_addr   = r_i[IDX_W-1:0];

        // Take a config write
        if (i_cfg_valid) begin
            n_mode = i_cfg_data;
        end

        // Drop the result once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_hold    = '{key_high: i_in_item.key_high,
                                  key_low:  i_in_item.key_low,
                                  peer:     i_in_item.peer_addr};
                    n_i       = '0;
                    n_uniq    = '0;
                    n_cap     = '0;
                    n_cap_dup = 1'b0;
                    n_cap_en  = 1'b0;
                    n_cap_idx = i_in_item.slot_index[IDX_W-1:0];
                    n_pos     = i_in_item.slot_index[IDX_W-1:0];
                    n_status  = 1'b0;
                    n_state   = S_UQ_RDI;
                    case (t_req_type'(i_in_item.req_type))
                        REQ_ADD: begin
                            n_state = S_ADD_RD;
                        end
                        REQ_MARK: begin
                            if (w_slot_oor) begin
                                n_status = 1'b1;
                            end else begin
                                n_state = S_MA_RD;
                            end
                        end
                        REQ_READ: begin
                            if (w_slot_oor) begin
                                n_status = 1'b1;
                            end else begin
                                n_cap_en = 1'b1;
                            end
                        end
                        default: begin
                            n_state = S_UQ_RDI;
                        end
                    endcase
                end
            end

            // Scan for an equal entry
            S_ADD_RD: begin
                if (r_i == r_count) begin
                    if (r_count < CNT_W'(MAX_ENTRIES)) begin
                        n_pos   = r_count[IDX_W-1:0];
                        n_count = r_count + 1'b1;
                    end else begin
                        n_pos = IDX_W'(MAX_ENTRIES - 1);
                    end
                    n_state = S_SH_RD;
                end else begin
                    w_rd_addr = r_i[IDX_W-1:0];
                    n_state   = S_ADD_CMP;
                end
            end

            S_ADD_CMP: begin
                if (w_hit) begin
                    n_hold  = w_rd_data;
                    n_pos   = r_i[IDX_W-1:0];
                    n_state = S_SH_RD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_ADD_RD;
                end
            end

            // Fetch the entry to move to the front
            S_MA_RD: begin
                w_rd_addr = r_pos;
                n_state   = S_MA_LD;
            end

            S_MA_LD: begin
                n_hold  = w_rd_data;
                n_state = S_SH_RD;
            end

            // Shift entries down one position, then place the held entry at the front
            S_SH_RD: begin
                if (r_pos == '0) begin
                    w_wr.we   = 1'b1;
                    w_wr.addr = '0;
                    w_wr.data = r_hold;
                    n_i       = '0;
                    n_state   = S_UQ_RDI;
                end else begin
                    w_rd_addr = r_pos - 1'b1;
                    n_state   = S_SH_WR;
                end
            end

            S_SH_WR: begin
                w_wr.we   = 1'b1;
                w_wr.addr = r_pos;
                w_wr.data = w_rd_data;
                n_pos     = r_pos - 1'b1;
                n_state   = S_SH_RD;
            end

            // Distinct key scan: outer entry
            S_UQ_RDI: begin
                if (r_i == r_count) begin
                    n_state = S_DONE;
                end else begin
                    w_rd_addr = r_i[IDX_W-1:0];
                    n_state   = S_UQ_LDI;
                end
            end

            S_UQ_LDI: begin
                n_hold  = w_rd_data;
                n_j     = '0;
                n_dup   = 1'b0;
                if (w_cap_here) begin
                    n_cap = w_rd_data;
                end
                n_state = S_UQ_RDJ;
            end

            // Distinct key scan: earlier entries
            S_UQ_RDJ: begin
                if (r_dup || (r_j == r_i)) begin
                    if (!r_dup) begin
                        n_uniq = r_uniq + 1'b1;
                    end
                    if (w_cap_here) begin
                        n_cap_dup = r_dup;
                    end
                    n_i     = r_i + 1'b1;
                    n_state = S_UQ_RDI;
                end else begin
                    w_rd_addr = r_j[IDX_W-1:0];
                    n_state   = S_UQ_CMP;
                end
            end

            S_UQ_CMP: begin
                if (w_hit) begin
                    n_dup = 1'b1;
                end
                n_j     = r_j + 1'b1;
                n_state = S_UQ_RDJ;
            end

            // Hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.out_key_high      = r_cap.key_high;
                    n_out.out_key_low       = r_cap.key_low;
                    n_out.out_peer_addr     = r_cap.peer;
                    n_out.earlier_duplicate = r_cap_dup;
                    n_out.entry_count       = CNT_OUT_W'(r_count);
                    n_out.unique_count      = CNT_OUT_W'(r_uniq);
                    n_out.op_status         = r_status;
                    n_out_valid             = 1'b1;
                    n_state                 = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
        r_hold    <= n_hold;
        r_i       <= n_i;
        r_j       <= n_j;
        r_pos     <= n_pos;
        r_uniq    <= n_uniq;
        r_dup     <= n_dup;
        r_cap_en  <= n_cap_en;
        r_cap_idx <= n_cap_idx;
        r_cap     <= n_cap;
        r_cap_dup <= n_cap_dup;
        r_status  <= n_status;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

/* rtl/core/mkt_checker.sv */
// mkt_checker: port-level assertions for mru_key_table, attached by bind.
// Depends on mkt_pkg and the top level mru_key_table.
`default_nettype none

module mkt_checker
    import mkt_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_item
);

    // Distinct keys never outnumber entries, and entries never exceed the depth
    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.unique_count <= o_out_item.entry_count) &&
                        (o_out_item.entry_count <= CNT_OUT_W'(MAX_ENTRIES)))
        else $error("count out of bounds");

    // A repeated key means fewer distinct keys than entries
    a_dup_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.earlier_duplicate) |->
            (o_out_item.unique_count < o_out_item.entry_count))
        else $error("duplicate flag without a repeated key");

    // A rejected request returns no entry data
    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.op_status) |->
            (o_out_item.out_key_high == '0) && (o_out_item.out_key_low == '0) &&
            (o_out_item.out_peer_addr == '0) && !o_out_item.earlier_duplicate)
        else $error("rejected request carries data");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind mru_key_table mkt_checker u_mkt_checker (.*);

`default_nettype wire

/* bench/mru_key_table_test.sv */
// mru_key_table_test: self-checking bench for the MRU key table, with random gaps and stalls.
// Depends on mkt_pkg and the mru_key_table RTL; predicts every result from its own table copy.
`timescale 1ns / 100ps

module mru_key_table_test;
    import mkt_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         SETTLE_CYCLES = 130;
    localparam int         MAX_PRINTED = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  in_item = '0;
    logic      o_out_valid;
    logic      out_stall = 1'b0;
    t_out_item o_out_item;
    logic      cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic      cfg_data = 1'b0;

    mru_key_table dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // Predicted table state
    t_entry      mru_slots [MAX_ENTRIES];
    int          held_entries = 0;
    bit          match_peer = 1'b0;

    t_in_item    pending_items [$];
    t_out_item   expected_results [$];
    logic [127:0] key_pool [$];
    logic [47:0] peer_pool [$];

    int          errors = 0;
    logic        in_taken = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    bit          calm = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Fail the run if it hangs
    initial begin
        #30_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // Shift positions below pos down by one and place e at the front
    function automatic void move_to_front(input int pos, input t_entry e);
        for (int i = pos; i > 0; i--) begin
            mru_slots[i] = mru_slots[i - 1];
        end
        mru_slots[0] = e;
    endfunction

    function automatic bit key_seen_earlier(input int pos);
        for (int i = 0; i < pos; i++) begin
            if (mru_slots[i].key_high == mru_slots[pos].key_high &&
                mru_slots[i].key_low == mru_slots[pos].key_low) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic int distinct_keys();
        int n;
        n = 0;
        for (int i = 0; i < held_entries; i++) begin
            if (!key_seen_earlier(i)) begin
                n++;
            end
        end
        return n;
    endfunction

    // Apply one request to the predicted table and return its result
    function automatic t_out_item apply_request(input t_in_item it);
        t_out_item res;
        t_entry    e;
        int        pos;
        bit        found;
        res = '0;
        found = 1'b0;
        pos = 0;
        case (it.req_type)
            REQ_ADD: begin
                e.key_high = it.key_high;
                e.key_low = it.key_low;
                e.peer = it.peer_addr;
                for (int i = 0; i < held_entries; i++) begin
                    if (!found && mru_slots[i].key_high == e.key_high &&
                        mru_slots[i].key_low == e.key_low &&
                        (!match_peer || mru_slots[i].peer == e.peer)) begin
                        found = 1'b1;
                        pos = i;
                    end
                end
                if (found) begin
                    move_to_front(pos, mru_slots[pos]);
                end else if (held_entries < MAX_ENTRIES) begin
                    move_to_front(held_entries, e);
                    held_entries++;
                end else begin
                    move_to_front(MAX_ENTRIES - 1, e);
                end
            end
            REQ_MARK, REQ_READ: begin
                pos = int'(it.slot_index);
                if (pos >= held_entries) begin
                    res.op_status = 1'b1;
                end else if (it.req_type == REQ_MARK) begin
                    move_to_front(pos, mru_slots[pos]);
                end else begin
                    res.out_key_high = mru_slots[pos].key_high;
                    res.out_key_low = mru_slots[pos].key_low;
                    res.out_peer_addr = mru_slots[pos].peer;
                    res.earlier_duplicate = key_seen_earlier(pos);
                end
            end
            default: ;
        endcase
        res.entry_count = CNT_OUT_W'(held_entries);
        res.unique_count = CNT_OUT_W'(distinct_keys());
        return res;
    endfunction

    task automatic check_result(input t_out_item got, input t_out_item want);
        if (got.out_key_high !== want.out_key_high)
            report_mismatch($sformatf("out_key_high got %h want %h",
                                      got.out_key_high, want.out_key_high));
        if (got.out_key_low !== want.out_key_low)
            report_mismatch($sformatf("out_key_low got %h want %h",
                                      got.out_key_low, want.out_key_low));
        if (got.out_peer_addr !== want.out_peer_addr)
            report_mismatch($sformatf("out_peer_addr got %h want %h",
                                      got.out_peer_addr, want.out_peer_addr));
        if (got.earlier_duplicate !== want.earlier_duplicate)
            report_mismatch($sformatf("earlier_duplicate got %b want %b",
                                      got.earlier_duplicate, want.earlier_duplicate));
        if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      got.entry_count, want.entry_count));
        if (got.unique_count !== want.unique_count)
            report_mismatch($sformatf("unique_count got %0d want %0d",
                                      got.unique_count, want.unique_count));
        if (got.op_status !== want.op_status)
            report_mismatch($sformatf("op_status got %b want %b",
                                      got.op_status, want.op_status));
    endtask

    // Mostly short pauses, a few long ones, none while calm
    function automatic int unsigned draw_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 150);
    endfunction

    function automatic t_in_item make_item(input logic [1:0] req, input logic [127:0] key,
                                           input logic [47:0] peer, input logic [3:0] slot);
        t_in_item it;
        it.req_type = req;
        it.key_high = key[127:64];
        it.key_low = key[63:0];
        it.peer_addr = peer;
        it.slot_index = slot;
        return it;
    endfunction

    function automatic logic [127:0] random_key();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [47:0] random_peer();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[47:0];
    endfunction

    // Keys and peers drawn mostly from small pools so that adds hit stored entries
    function automatic t_in_item make_random_item();
        int unsigned  r;
        logic [1:0]   req;
        logic [127:0] key;
        logic [47:0]  peer;
        logic [3:0]   slot;
        r = $urandom_range(0, 99);
        if (r < 45) req = REQ_ADD;
        else if (r < 65) req = REQ_MARK;
        else if (r < 95) req = REQ_READ;
        else req = REQ_UNUSED;
        if ($urandom_range(0, 99) < 85)
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else
            key = random_key();
        if ($urandom_range(0, 99) < 80)
            peer = peer_pool[$urandom_range(0, peer_pool.size() - 1)];
        else
            peer = random_peer();
        if ($urandom_range(0, 99) < 70)
            slot = 4'($urandom_range(0, MAX_ENTRIES - 1));
        else
            slot = 4'($urandom_range(0, 15));
        return make_item(req, key, peer, slot);
    endfunction

    function automatic void fill_pools(input int n_keys);
        key_pool.delete();
        peer_pool.delete();
        for (int i = 0; i < n_keys; i++) key_pool.push_back(random_key());
        for (int i = 0; i < 3; i++) peer_pool.push_back(random_peer());
    endfunction

    // Wait until nothing is queued, in flight or expected, then let the block settle
    task automatic wait_idle();
        do @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_match_peer(input bit value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk);
        while (!o_cfg_ready);
        match_peer = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Toggle stretches with no idling on either side
    always @(negedge clk) begin
        if ($urandom_range(0, 299) == 0) calm <= !calm;
    end

    // Request driver: hold a stalled item, otherwise pause or present the next one
    always @(negedge clk) begin
        if (rst_n && !(in_valid && !in_taken)) begin
            if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_items.size() > 0) begin
                in_item <= pending_items.pop_front();
                in_valid <= 1'b1;
                gap_left <= draw_pause();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure
    always @(negedge clk) begin : stall_drive
        int unsigned n;
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            n = draw_pause();
            out_stall <= (n != 0);
            stall_left <= (n == 0) ? 0 : n - 1;
        end
    end

    // Check results against the oldest expectation, then predict the item taken
    always @(posedge clk) begin : monitor
        t_out_item want;
        if (rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result arrived with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    check_result(o_out_item, want);
                end
            end
            if (in_valid && !o_in_stall) begin
                expected_results.push_back(apply_request(in_item));
            end
            in_taken <= in_valid && !o_in_stall;
        end
    end

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        write_match_peer(1'b0);
        fill_pools(12);

        // Empty table, unused code, extreme keys and peers
        pending_items.push_back(make_item(REQ_READ, random_key(), random_peer(), 4'd0));
        pending_items.push_back(make_item(REQ_MARK, random_key(), random_peer(), 4'd15));
        pending_items.push_back(make_item(REQ_UNUSED, '1, '1, 4'd15));
        pending_items.push_back(make_item(REQ_ADD, '0, '0, 4'd15));
        pending_items.push_back(make_item(REQ_ADD, '1, '1, 4'd0));
        pending_items.push_back(make_item(REQ_ADD, '1, '0, 4'd3));
        pending_items.push_back(make_item(REQ_ADD, '0, '1, 4'd0));
        pending_items.push_back(make_item(REQ_READ, '1, '1, 4'd1));
        pending_items.push_back(make_item(REQ_MARK, '1, '1, 4'd0));
        pending_items.push_back(make_item(REQ_MARK, '0, '0, 4'd1));
        // Fill past capacity so the oldest entries drop off
        for (int i = 0; i < MAX_ENTRIES; i++)
            pending_items.push_back(make_item(REQ_ADD, key_pool[i], peer_pool[i % 3], 4'd0));
        pending_items.push_back(make_item(REQ_READ, random_key(), random_peer(), 4'(MAX_ENTRIES - 1)));
        pending_items.push_back(make_item(REQ_READ, random_key(), random_peer(), 4'(MAX_ENTRIES)));
        pending_items.push_back(make_item(REQ_READ, random_key(), random_peer(), 4'd15));
        pending_items.push_back(make_item(REQ_MARK, random_key(), random_peer(), 4'(MAX_ENTRIES - 1)));
        for (int i = 0; i < 300; i++) pending_items.push_back(make_random_item());
        wait_idle();

        // Peer compare on: same key with a new peer becomes a second entry
        write_match_peer(1'b1);
        pending_items.push_back(make_item(REQ_ADD, key_pool[0], peer_pool[0], 4'd0));
        pending_items.push_back(make_item(REQ_ADD, key_pool[0], ~peer_pool[0], 4'd0));
        pending_items.push_back(make_item(REQ_READ, random_key(), random_peer(), 4'd1));
        fill_pools(5);
        for (int i = 0; i < 250; i++) pending_items.push_back(make_random_item());
        wait_idle();

        write_match_peer(1'b0);
        fill_pools(14);
        for (int i = 0; i < 250; i++) pending_items.push_back(make_random_item());
        wait_idle();

        write_match_peer(1'b1);
        fill_pools(9);
        for (int i = 0; i < 200; i++) pending_items.push_back(make_random_item());
        wait_idle();

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/mkt_pkg.sv
rtl/core/mkt_store.sv
rtl/core/mru_key_table.sv
rtl/core/mkt_checker.sv
bench/mru_key_table_test.sv
